FILE: hdl/tdt_pkg.sv
// Shared types and constants for the timed departure table.
// Used by the top level, controller and datapath of the block; depends on nothing else.
`timescale 1ns / 1ps

package tdt_pkg;

    localparam int SECS_PER_MIN  = 60;
    localparam int MINS_PER_HOUR = 60;
    localparam int HOURS_PER_DAY = 24;

    localparam logic REG_START_HOUR   = 1'b0;
    localparam logic REG_START_MINUTE = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_DEPARTED = 2'd1,
        EV_ADDED    = 2'd2,
        EV_FULL     = 2'd3
    } event_t;

    typedef enum logic [0:0] {
        KIND_TICK = 1'b0,
        KIND_ADD  = 1'b1
    } kind_t;

    typedef struct packed {
        logic [4:0]  due_hour;
        logic [5:0]  due_minute;
        logic [15:0] passengers;
        logic [15:0] dest_tag;
        logic [15:0] airline_tag;
    } entry_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  due_hour;
        logic [5:0]  due_minute;
        logic [15:0] passengers;
        logic [15:0] dest_tag;
        logic [15:0] airline_tag;
    } item_t;

    typedef struct packed {
        event_t      event_res;
        logic [4:0]  position;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [15:0] out_passengers;
        logic [15:0] out_dest;
        logic [15:0] out_airline;
        logic [4:0]  clock_hour;
        logic [5:0]  clock_minute;
        logic [5:0]  clock_second;
        logic [4:0]  occupancy;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_ROLL,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic latch;
        logic add;
        logic roll;
        logic scan;
        logic shift;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic drained;
    } stat_t;

    typedef struct packed {
        logic       hour_we;
        logic       minute_we;
        logic [4:0] hour;
        logic [5:0] minute;
    } cfg_t;

endpackage

FILE: hdl/timed_departure_table.sv
// Top level of the timed departure table: handshake, configuration port and block wiring.
// Depends on tdt_pkg, tdt_ctrl and tdt_dp (which holds the tdt_ram entry store).
`timescale 1ns / 1ps

// An item beat is taken when start is high and busy is low; busy stays high until the
// result is produced. Each item gives exactly one result beat, shown for one cycle with
// done high, and the receiver cannot stall it. An add item's result is registered in the
// add state. A tick item ends once the search for a due entry and the closing of the gap,
// which walk the entry store one entry per cycle through its single read port, are done.
// The entry store holds no reset values and needs no clearing pass. Configuration writes
// to start_hour or start_minute load the running clock at once and are to be made by the
// user while the block is idle; the block itself does not enforce this.

module timed_departure_table #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tdt_pkg::item_t   item,
    output logic             done,
    output tdt_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import tdt_pkg::*;

    logic [4:0] start_hour_reg;
    logic [5:0] start_minute_reg;
    logic       cfg_write;
    cfg_t       cfg;
    cmd_t       cmd;
    stat_t      stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign cfg.hour_we   = cfg_write && (paddr[2] == REG_START_HOUR);
    assign cfg.minute_we = cfg_write && (paddr[2] == REG_START_MINUTE);
    assign cfg.hour      = pwdata[4:0];
    assign cfg.minute    = pwdata[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_hour_reg   <= '0;
            start_minute_reg <= '0;
        end
        else
        begin
            if (cfg.hour_we)
            begin
                start_hour_reg <= cfg.hour;
            end
            if (cfg.minute_we)
            begin
                start_minute_reg <= cfg.minute;
            end
        end
    end

    assign prdata = (paddr[2] == REG_START_HOUR) ? {27'd0, start_hour_reg}
                                                 : {26'd0, start_minute_reg};

    tdt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (item.kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    tdt_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .cfg    (cfg),
        .stat   (stat),
        .result (result)
    );

endmodule

FILE: hdl/tdt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the entry store of the departure table.
`timescale 1ns / 1ps

module tdt_ram #(
    parameter int WIDTH = 59,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/tdt_ctrl.sv
// Controller state machine of the departure table: sequences add, rollover, scan, shift and finish.
// Depends on tdt_pkg; drives commands to tdt_dp and reads its status.
`timescale 1ns / 1ps

module tdt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tdt_pkg::kind_t kind,
    input  tdt_pkg::stat_t stat,
    output tdt_pkg::cmd_t  cmd,
    output logic          busy,
    output logic          done
);

    import tdt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = (kind == KIND_ADD) ? ST_ADD : ST_ROLL;
                end
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ROLL:
            begin
                cmd.roll   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    state_next = ST_SHIFT;
                end
                else if (stat.drained)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.drained)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        done_next = cmd.add | cmd.finish;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

FILE: hdl/tdt_dp.sv
// Datapath of the departure table: clock, entry count, scan and compaction pointers, result.
// Depends on tdt_pkg and tdt_ram; driven by commands from tdt_ctrl.
`timescale 1ns / 1ps

module tdt_dp #(
    parameter int DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tdt_pkg::cmd_t   cmd,
    input  tdt_pkg::item_t  item,
    input  tdt_pkg::cfg_t   cfg,
    output tdt_pkg::stat_t  stat,
    output tdt_pkg::result_t result
);

    import tdt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    item_t         item_reg;
    entry_t        dep_reg,    dep_next;
    result_t       res_reg,    res_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [CW-1:0] idx_reg,    idx_next;
    logic [CW-1:0] dst_reg,    dst_next;
    logic [CW-1:0] pos_reg,    pos_next;
    logic          pend_reg,   pend_next;
    logic          found_reg,  found_next;
    logic [4:0]    hour_reg,   hour_next;
    logic [5:0]    minute_reg, minute_next;
    logic [5:0]    second_reg, second_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic          ram_re;
    entry_t        ram_rdata;

    logic [6:0]    minute_inc;
    logic [5:0]    hour_inc;
    logic [5:0]    second_inc;
    logic          more;
    logic          not_full;
    logic          match;
    logic [CW-1:0] count_dec;
    logic [CW-1:0] count_inc;
    logic [31:0]   pos_wide;
    logic [31:0]   count_inc_wide;
    logic [31:0]   count_wide;
    logic [31:0]   count_dec_wide;

    tdt_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign minute_inc     = {1'b0, minute_reg} + 7'd1;
    assign hour_inc       = {1'b0, hour_reg} + 6'd1;
    assign second_inc     = second_reg + 6'd1;
    assign more           = (idx_reg < count_reg);
    assign not_full       = (count_reg < CW'(DEPTH));
    assign match          = pend_reg && (ram_rdata.due_hour == hour_reg)
                            && (ram_rdata.due_minute == minute_reg);
    assign count_dec      = count_reg - CW'(1);
    assign count_inc      = count_reg + CW'(1);
    assign pos_wide       = 32'(pos_reg);
    assign count_inc_wide = 32'(count_inc);
    assign count_wide     = 32'(count_reg);
    assign count_dec_wide = 32'(count_dec);

    assign stat.hit     = cmd.scan && match;
    assign stat.drained = !pend_reg && !more;

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        dst_next    = dst_reg;
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        found_next  = found_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        dep_next    = dep_reg;
        res_next    = res_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_wdata   = {item_reg.due_hour, item_reg.due_minute, item_reg.passengers,
                       item_reg.dest_tag, item_reg.airline_tag};
        ram_re      = 1'b0;

        if (cfg.hour_we)
        begin
            hour_next = cfg.hour;
        end
        if (cfg.minute_we)
        begin
            minute_next = cfg.minute;
        end

        if (cmd.add)
        begin
            res_next                = '0;
            res_next.clock_hour     = hour_reg;
            res_next.clock_minute   = minute_reg;
            res_next.clock_second   = second_reg;
            if (not_full)
            begin
                ram_we             = 1'b1;
                count_next         = count_inc;
                res_next.event_res = EV_ADDED;
                res_next.position  = count_inc_wide[4:0];
                res_next.occupancy = count_inc_wide[4:0];
            end
            else
            begin
                res_next.event_res = EV_FULL;
                res_next.occupancy = count_wide[4:0];
            end
        end

        if (cmd.roll)
        begin
            idx_next   = '0;
            pend_next  = 1'b0;
            found_next = 1'b0;
            if (second_reg >= 6'(SECS_PER_MIN))
            begin
                second_next = '0;
                if (minute_inc >= 7'(MINS_PER_HOUR))
                begin
                    minute_next = '0;
                    hour_next   = (hour_inc >= 6'(HOURS_PER_DAY)) ? 5'd0 : hour_inc[4:0];
                end
                else
                begin
                    minute_next = minute_inc[5:0];
                end
            end
        end

        if (cmd.scan)
        begin
            if (match)
            begin
                found_next = 1'b1;
                dep_next   = ram_rdata;
                pos_next   = idx_reg;
                dst_next   = idx_reg - CW'(1);
                pend_next  = 1'b0;
            end
            else
            begin
                ram_re    = more;
                pend_next = more;
                if (more)
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
        end

        if (cmd.shift)
        begin
            ram_re    = more;
            pend_next = more;
            if (more)
            begin
                idx_next = idx_reg + CW'(1);
            end
            if (pend_reg)
            begin
                ram_we    = 1'b1;
                ram_waddr = dst_reg[AW-1:0];
                ram_wdata = ram_rdata;
                dst_next  = dst_reg + CW'(1);
            end
        end

        if (cmd.finish)
        begin
            second_next           = second_inc;
            res_next              = '0;
            res_next.clock_hour   = hour_reg;
            res_next.clock_minute = minute_reg;
            res_next.clock_second = second_inc;
            res_next.occupancy    = count_wide[4:0];
            if (found_reg)
            begin
                count_next              = count_dec;
                res_next.event_res      = EV_DEPARTED;
                res_next.position       = pos_wide[4:0];
                res_next.out_hour       = dep_reg.due_hour;
                res_next.out_minute     = dep_reg.due_minute;
                res_next.out_passengers = dep_reg.passengers;
                res_next.out_dest       = dep_reg.dest_tag;
                res_next.out_airline    = dep_reg.airline_tag;
                res_next.occupancy      = count_dec_wide[4:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            dst_reg    <= '0;
            pos_reg    <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            dst_reg    <= dst_next;
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= item;
        end
        dep_reg <= dep_next;
        res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

FILE: tb/timed_departure_table_checker.sv
// Checker for the timed departure table: predicts each result beat and compares it.
// Watches the item, result and configuration channels; depends on tdt_pkg only.
`timescale 1ns / 1ps

module timed_departure_table_checker #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  tdt_pkg::item_t   item,
    input  logic             done,
    input  tdt_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    input  logic             pready,
    output int               errors,
    output int               outstanding,
    output int               departures,
    output int               rejections
);
    import tdt_pkg::*;

    entry_t   slots [DEPTH];
    int       held;
    int       wall_hour;
    int       wall_minute;
    int       wall_second;
    result_t  predicted_events [$];
    result_t  oldest;

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic compare_result(result_t got, result_t want);
        check_field("event_res", 16'(got.event_res), 16'(want.event_res));
        check_field("position", 16'(got.position), 16'(want.position));
        check_field("out_hour", 16'(got.out_hour), 16'(want.out_hour));
        check_field("out_minute", 16'(got.out_minute), 16'(want.out_minute));
        check_field("out_passengers", got.out_passengers, want.out_passengers);
        check_field("out_dest", got.out_dest, want.out_dest);
        check_field("out_airline", got.out_airline, want.out_airline);
        check_field("clock_hour", 16'(got.clock_hour), 16'(want.clock_hour));
        check_field("clock_minute", 16'(got.clock_minute), 16'(want.clock_minute));
        check_field("clock_second", 16'(got.clock_second), 16'(want.clock_second));
        check_field("occupancy", 16'(got.occupancy), 16'(want.occupancy));
    endtask

    function automatic result_t advance_schedule(item_t it);
        result_t r;
        int      i;
        int      k;
        r = '0;
        if (it.kind == KIND_ADD)
        begin
            if (held < DEPTH)
            begin
                slots[held] = {it.due_hour, it.due_minute, it.passengers, it.dest_tag,
                               it.airline_tag};
                held++;
                r.event_res = EV_ADDED;
                r.position  = 5'(held);
            end
            else
            begin
                r.event_res = EV_FULL;
            end
        end
        else
        begin
            if (wall_second >= SECS_PER_MIN)
            begin
                wall_second = 0;
                wall_minute++;
                if (wall_minute >= MINS_PER_HOUR)
                begin
                    wall_minute = 0;
                    wall_hour++;
                    if (wall_hour >= HOURS_PER_DAY)
                    begin
                        wall_hour = 0;
                    end
                end
            end
            i = 0;
            while (i < held && !(int'(slots[i].due_hour) == wall_hour &&
                                 int'(slots[i].due_minute) == wall_minute))
            begin
                i++;
            end
            if (i < held)
            begin
                r.event_res      = EV_DEPARTED;
                r.position       = 5'(i + 1);
                r.out_hour       = slots[i].due_hour;
                r.out_minute     = slots[i].due_minute;
                r.out_passengers = slots[i].passengers;
                r.out_dest       = slots[i].dest_tag;
                r.out_airline    = slots[i].airline_tag;
                for (k = i; k + 1 < held; k++)
                begin
                    slots[k] = slots[k + 1];
                end
                held--;
            end
            wall_second = (wall_second + 1) & 63;
        end
        r.clock_hour   = 5'(wall_hour);
        r.clock_minute = 6'(wall_minute);
        r.clock_second = 6'(wall_second);
        r.occupancy    = 5'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held        = 0;
            wall_hour   = 0;
            wall_minute = 0;
            wall_second = 0;
            errors      = 0;
            departures  = 0;
            rejections  = 0;
            predicted_events.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (predicted_events.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected", 16'd1, 16'd0);
                end
                else
                begin
                    oldest = predicted_events.pop_front();
                    compare_result(result, oldest);
                    if (oldest.event_res == EV_DEPARTED)
                    begin
                        departures++;
                    end
                    if (oldest.event_res == EV_FULL)
                    begin
                        rejections++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_START_HOUR)
                begin
                    wall_hour = int'(pwdata[4:0]);
                end
                else
                begin
                    wall_minute = int'(pwdata[5:0]);
                end
            end
            if (start && !busy)
            begin
                predicted_events.push_back(advance_schedule(item));
            end
            outstanding <= predicted_events.size();
        end
    end

endmodule

FILE: tb/timed_departure_table_tb.sv
// Top of the timed departure table testbench: clock, reset, item and register stimulus.
// Depends on tdt_pkg, timed_departure_table and timed_departure_table_checker.
`timescale 1ns / 1ps

module timed_departure_table_tb;
    import tdt_pkg::*;

    localparam int DEPTH      = 16;
    localparam int IDLE_LIMIT = 3000;
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 120;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    item_t       item    = '0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic        busy;
    logic        done;
    result_t     result;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int outstanding;
    int departures;
    int rejections;
    int n_ticks     = 0;
    int n_adds      = 0;
    int n_writes    = 0;
    int idle_cycles = 0;
    int calm_left   = 0;

    logic [4:0] seen_hour      = '0;
    logic [5:0] seen_minute    = '0;
    logic [4:0] seen_occupancy = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    timed_departure_table #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    timed_departure_table_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .errors      (errors),
        .outstanding (outstanding),
        .departures  (departures),
        .rejections  (rejections)
    );

    always @(posedge clk)
    begin
        if (done)
        begin
            seen_hour      <= result.clock_hour;
            seen_minute    <= result.clock_minute;
            seen_occupancy <= result.occupancy;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (psel && penable && pwrite))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("No handshake for %0d cycles, giving up.", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic item_t tick_item();
        item_t it;
        it.kind        = KIND_TICK;
        it.due_hour    = 5'($urandom);
        it.due_minute  = 6'($urandom);
        it.passengers  = 16'($urandom);
        it.dest_tag    = 16'($urandom);
        it.airline_tag = 16'($urandom);
        return it;
    endfunction

    function automatic item_t add_item(logic [4:0] h, logic [5:0] m, logic [15:0] p,
                                       logic [15:0] d, logic [15:0] a);
        item_t it;
        it.kind        = KIND_ADD;
        it.due_hour    = h;
        it.due_minute  = m;
        it.passengers  = p;
        it.dest_tag    = d;
        it.airline_tag = a;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t      it;
        int         pick;
        logic [4:0] h;
        logic [5:0] m;
        it = tick_item();
        if ($urandom_range(0, 99) < 62)
        begin
            return it;
        end
        it.kind = KIND_ADD;
        pick = $urandom_range(0, 99);
        h = seen_hour;
        m = seen_minute;
        if (pick >= 55 && pick < 85)
        begin
            if (m >= 59)
            begin
                m = 0;
                h = (h >= 23) ? 5'd0 : h + 5'd1;
            end
            else
            begin
                m = m + 6'd1;
            end
        end
        else if (pick >= 85 && pick < 97 && seen_occupancy < 8)
        begin
            h = 5'($urandom_range(0, 23));
            m = 6'($urandom_range(0, 59));
        end
        else if (pick >= 97 && seen_occupancy < 4)
        begin
            h = 5'($urandom);
            m = 6'($urandom);
        end
        it.due_hour   = h;
        it.due_minute = m;
        return it;
    endfunction

    task automatic send_item(item_t it);
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (it.kind == KIND_ADD)
        begin
            n_adds++;
        end
        else
        begin
            n_ticks++;
        end
    endtask

    task automatic gap();
        int n;
        int pick;
        n = 0;
        if (calm_left > 0)
        begin
            calm_left--;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                calm_left = 30;
            end
            pick = $urandom_range(0, 99);
            if (pick >= 90)
            begin
                n = $urandom_range(8, 40);
            end
            else if (pick >= 55)
            begin
                n = $urandom_range(1, 3);
            end
        end
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            item  <= tick_item();
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic apb_write(logic reg_sel, logic [5:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= ($urandom & ~32'h3F) | 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_writes++;
    endtask

    task automatic configure(logic [4:0] h, logic [5:0] m);
        apb_write(REG_START_HOUR, 6'(h));
        apb_write(REG_START_MINUTE, m);
    endtask

    initial
    begin
        int         k;
        int         phase;
        logic [4:0] h;
        logic [5:0] m;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        configure(5'd0, 6'd0);

        send_item(tick_item());
        send_item(add_item(5'd0, 6'd0, 16'h0000, 16'h0000, 16'h0000));
        send_item(add_item(5'd31, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(tick_item());
        gap();
        send_item(tick_item());
        for (k = 0; k < 15; k++)
        begin
            case (k)
                1:
                begin
                    h = 5'd23;
                    m = 6'd59;
                end
                3, 14:
                begin
                    h = 5'd0;
                    m = 6'd0;
                end
                default:
                begin
                    h = 5'd1;
                    m = 6'(k);
                end
            endcase
            send_item(add_item(h, m, 16'($urandom), 16'($urandom), 16'($urandom)));
            gap();
        end
        send_item(add_item(5'd2, 6'd2, 16'($urandom), 16'($urandom), 16'($urandom)));
        send_item(tick_item());
        gap();
        send_item(tick_item());

        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0: configure(5'd23, 6'd59);
                1: configure(5'd31, 6'd63);
                2: configure(5'd0, 6'd0);
                default: configure(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
            endcase
            repeat (PHASE_LEN)
            begin
                send_item(random_item());
                gap();
            end
        end

        settle();
        repeat (DEPTH + 8) @(posedge clk);

        $display("Ran %0d ticks and %0d adds across %0d register writes.",
                 n_ticks, n_adds, n_writes);
        $display("Saw %0d departures and %0d rejected adds on a full board.",
                 departures, rejections);
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
